// ===== design/hhmmc_pkg.sv =====
package hhmmc_pkg;

    // Register indexes of the configuration port
    localparam logic [1:0] REG_TICKS_PER_SECOND  = 2'd0;
    localparam logic [1:0] REG_BLINK_HALF_PERIOD = 2'd1;
    localparam logic [1:0] REG_LONG_PRESS_POLLS  = 2'd2;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Register reset values
    localparam logic [15:0] TICKS_PER_SECOND_RST  = 16'd1000;
    localparam logic [15:0] BLINK_HALF_PERIOD_RST = 16'd500;
    localparam logic [7:0]  LONG_PRESS_POLLS_RST  = 8'd30;

    // Display geometry
    localparam int NUM_DIGITS = 4;
    localparam int SCAN_W     = $clog2(NUM_DIGITS);

    // Time limits
    localparam logic [5:0] SEC_MAX  = 6'd59;
    localparam logic [5:0] MIN_MAX  = 6'd59;
    localparam logic [4:0] HOUR_MAX = 5'd23;

    // Setting mode codes
    localparam logic [1:0] MODE_RUN  = 2'd0;
    localparam logic [1:0] MODE_HOUR = 2'd1;
    localparam logic [1:0] MODE_MIN  = 2'd2;

    // Request kinds
    localparam logic REQ_TICK = 1'b0;
    localparam logic REQ_POLL = 1'b1;

    // Button slots of the hold counters
    localparam int BTN_MODE = 0;
    localparam int BTN_UP   = 1;
    localparam int BTN_DOWN = 2;
    localparam int NUM_BTNS = 3;

    // Blank display for poll results
    localparam logic [7:0] SEG_BLANK    = 8'hFF;
    localparam logic [3:0] STROBE_BLANK = 4'hF;

    typedef struct packed {
        logic req_type;
        logic mode_button;
        logic up_button;
        logic down_button;
    } t_req;

    typedef struct packed {
        logic [7:0] segments;
        logic [3:0] digit_enable;
        logic       blink_led;
        logic       buzzer_pulse;
        logic [4:0] hours;
        logic [5:0] minutes;
        logic [5:0] seconds;
        logic [1:0] set_mode;
    } t_rsp;

    // Active-low seven-segment pattern of a decimal digit
    function automatic logic [7:0] seg_of(input logic [3:0] digit);
        logic [7:0] seg;
        case (digit)
            4'd0:    seg = 8'hC0;
            4'd1:    seg = 8'hF9;
            4'd2:    seg = 8'hA4;
            4'd3:    seg = 8'hB0;
            4'd4:    seg = 8'h99;
            4'd5:    seg = 8'h92;
            4'd6:    seg = 8'h82;
            4'd7:    seg = 8'hF8;
            4'd8:    seg = 8'h80;
            4'd9:    seg = 8'h90;
            default: seg = 8'hC0;
        endcase
        return seg;
    endfunction

endpackage

// ===== design/hhmmc_stream_if.sv =====
interface hhmmc_stream_if #(
    parameter type t_payload = logic
) ();
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== design/hhmm_clock_with_setting_and_scan.sv =====
// 24-hour clock with button setting and a four-digit multiplexed display.
// Request channel i_req carries either a timer tick or a button poll sample.
// A tick advances the second and blink counters, steps the time with minute
// and hour carry, and drives the next digit of HHMM (active-low segments and
// strobe). A poll updates the hold counters of the mode, up and down buttons:
// a long mode hold enters hour setting and raises buzzer_pulse, short releases
// step the mode or change the selected field. A poll result shows a blank
// display.
// Every request gives exactly one result on o_rsp, loaded into the single
// output register on acceptance. One request is taken every cycle unless
// the receiver stalls; the register then holds the result, and i_req stays
// ready whenever it is empty or being drained in the same cycle.
// Registers are written through i_cfg_we / i_cfg_idx / i_cfg_data and should
// change only while the block is idle. Synchronous active-low reset sets the
// time to 00:00:00, run mode, cleared counters, and the register defaults.
module hhmm_clock_with_setting_and_scan (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    hhmmc_stream_if.sink                     i_req,
    hhmmc_stream_if.source                   o_rsp,
    input  logic                             i_cfg_we,
    input  logic [hhmmc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [hhmmc_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    typedef struct packed {
        logic [7:0] cnt;
        logic       short_rel;
    } t_poll;

    typedef struct packed {
        logic [3:0] tens;
        logic [3:0] ones;
    } t_digits;

    // Configuration registers
    logic [15:0] r_tps;
    logic [15:0] r_blink_half;
    logic [7:0]  r_long_polls;

    // Clock state
    logic [15:0]                    r_sec_cnt,   n_sec_cnt;
    logic [15:0]                    r_blink_cnt, n_blink_cnt;
    logic                           r_blink,     n_blink;
    logic [5:0]                     r_sec,       n_sec;
    logic [5:0]                     r_min,       n_min;
    logic [4:0]                     r_hour,      n_hour;
    logic [1:0]                     r_mode,      n_mode;
    logic [hhmmc_pkg::SCAN_W-1:0]   r_scan,      n_scan;
    logic [7:0]                     r_press [hhmmc_pkg::NUM_BTNS];
    logic [7:0]                     n_press [hhmmc_pkg::NUM_BTNS];
    logic                           r_long_fired, n_long_fired;

    // Result register
    hhmmc_pkg::t_rsp r_out, n_out;
    logic            r_out_valid;

    logic    req_fire;
    t_poll   poll_mode, poll_up, poll_down;
    t_digits hour_dig, min_dig;
    logic [3:0] disp_digit;

    function automatic logic [4:0] hour_inc(input logic [4:0] h);
        return (h >= hhmmc_pkg::HOUR_MAX) ? 5'd0 : h + 5'd1;
    endfunction

    // Advance a hold counter; flag a short release
    function automatic t_poll poll_btn(input logic [7:0] cnt, input logic level,
                                       input logic [7:0] limit);
        t_poll p;
        p.short_rel = 1'b0;
        p.cnt       = cnt;
        if (level) begin
            if (cnt < limit) p.cnt = cnt + 8'd1;
        end else begin
            p.short_rel = (cnt != 8'd0) && (cnt < limit);
            p.cnt       = 8'd0;
        end
        return p;
    endfunction

    // Split a value below 64 into decimal tens and ones
    function automatic t_digits split_dec(input logic [5:0] v);
        t_digits d;
        logic [5:0] prod;
        d.tens = 4'd0;
        for (int k = 1; k <= 6; k++) begin
            if (v >= 6'(10 * k)) d.tens = 4'(k);
        end
        prod   = {2'b00, d.tens} * 6'd10;
        d.ones = 4'(v - prod);
        return d;
    endfunction

    assign req_fire    = i_req.valid && i_req.ready;
    assign i_req.ready = !r_out_valid || o_rsp.ready;
    assign o_rsp.valid = r_out_valid;
    assign o_rsp.payload = r_out;

    // Compute next state and result for the accepted request
    always_comb begin
        n_sec_cnt    = r_sec_cnt;
        n_blink_cnt  = r_blink_cnt;
        n_blink      = r_blink;
        n_sec        = r_sec;
        n_min        = r_min;
        n_hour       = r_hour;
        n_mode       = r_mode;
        n_scan       = r_scan;
        n_press      = r_press;
        n_long_fired = r_long_fired;
        poll_mode    = poll_btn(r_press[hhmmc_pkg::BTN_MODE], i_req.payload.mode_button,
                                r_long_polls);
        poll_up      = '0;
        poll_down    = '0;
        hour_dig     = '0;
        min_dig      = '0;
        disp_digit   = '0;
        n_out.segments     = hhmmc_pkg::SEG_BLANK;
        n_out.digit_enable = hhmmc_pkg::STROBE_BLANK;
        n_out.buzzer_pulse = 1'b0;

        if (i_req.payload.req_type == hhmmc_pkg::REQ_TICK) begin
            // Advance sub-second and blink counters
            n_sec_cnt   = r_sec_cnt + 16'd1;
            n_blink_cnt = r_blink_cnt + 16'd1;
            if (n_blink_cnt >= r_blink_half) begin
                n_blink     = !r_blink;
                n_blink_cnt = 16'd0;
            end
            // Step the time with carry
            if (n_sec_cnt >= r_tps) begin
                n_sec_cnt = 16'd0;
                if (r_sec >= hhmmc_pkg::SEC_MAX) begin
                    n_sec = 6'd0;
                    if (r_min >= hhmmc_pkg::MIN_MAX) begin
                        n_min  = 6'd0;
                        n_hour = hour_inc(r_hour);
                    end else begin
                        n_min = r_min + 6'd1;
                    end
                end else begin
                    n_sec = r_sec + 6'd1;
                end
            end
            // Drive the current digit with the updated time
            hour_dig = split_dec({1'b0, n_hour});
            min_dig  = split_dec(n_min);
            case (r_scan)
                2'd0:    disp_digit = hour_dig.tens;
                2'd1:    disp_digit = hour_dig.ones;
                2'd2:    disp_digit = min_dig.tens;
                default: disp_digit = min_dig.ones;
            endcase
            n_out.segments     = hhmmc_pkg::seg_of(disp_digit);
            n_out.digit_enable = ~(4'b0001 << r_scan);
            n_scan = (r_scan == hhmmc_pkg::SCAN_W'(hhmmc_pkg::NUM_DIGITS - 1))
                     ? '0 : r_scan + 1'b1;
        end else begin
            // Mode button: short release steps the setting mode
            n_press[hhmmc_pkg::BTN_MODE] = poll_mode.cnt;
            if (poll_mode.short_rel) begin
                if (r_mode == hhmmc_pkg::MODE_HOUR)     n_mode = hhmmc_pkg::MODE_MIN;
                else if (r_mode == hhmmc_pkg::MODE_MIN) n_mode = hhmmc_pkg::MODE_RUN;
            end
            // Long mode hold fires once per hold
            if (i_req.payload.mode_button) begin
                if (poll_mode.cnt >= r_long_polls && !r_long_fired) begin
                    n_out.buzzer_pulse = 1'b1;
                    n_mode             = hhmmc_pkg::MODE_HOUR;
                    n_long_fired       = 1'b1;
                end
            end else begin
                n_long_fired = 1'b0;
            end
            // Up button: increment the selected field
            poll_up = poll_btn(r_press[hhmmc_pkg::BTN_UP], i_req.payload.up_button,
                               r_long_polls);
            n_press[hhmmc_pkg::BTN_UP] = poll_up.cnt;
            if (poll_up.short_rel) begin
                if (n_mode == hhmmc_pkg::MODE_HOUR) begin
                    n_hour = hour_inc(n_hour);
                end else if (n_mode == hhmmc_pkg::MODE_MIN) begin
                    if (n_min >= hhmmc_pkg::MIN_MAX) begin
                        n_min  = 6'd0;
                        n_hour = hour_inc(n_hour);
                    end else begin
                        n_min = n_min + 6'd1;
                    end
                end
            end
            // Down button: decrement the selected field without borrow
            poll_down = poll_btn(r_press[hhmmc_pkg::BTN_DOWN], i_req.payload.down_button,
                                 r_long_polls);
            n_press[hhmmc_pkg::BTN_DOWN] = poll_down.cnt;
            if (poll_down.short_rel) begin
                if (n_mode == hhmmc_pkg::MODE_HOUR) begin
                    n_hour = (n_hour == 5'd0 || n_hour > hhmmc_pkg::HOUR_MAX)
                             ? hhmmc_pkg::HOUR_MAX : n_hour - 5'd1;
                end else if (n_mode == hhmmc_pkg::MODE_MIN) begin
                    n_min = (n_min == 6'd0 || n_min > hhmmc_pkg::MIN_MAX)
                            ? hhmmc_pkg::MIN_MAX : n_min - 6'd1;
                end
            end
        end

        n_out.blink_led = n_blink;
        n_out.hours     = n_hour;
        n_out.minutes   = n_min;
        n_out.seconds   = n_sec;
        n_out.set_mode  = n_mode;
    end

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tps        <= hhmmc_pkg::TICKS_PER_SECOND_RST;
            r_blink_half <= hhmmc_pkg::BLINK_HALF_PERIOD_RST;
            r_long_polls <= hhmmc_pkg::LONG_PRESS_POLLS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                hhmmc_pkg::REG_TICKS_PER_SECOND:  r_tps        <= i_cfg_data;
                hhmmc_pkg::REG_BLINK_HALF_PERIOD: r_blink_half <= i_cfg_data;
                hhmmc_pkg::REG_LONG_PRESS_POLLS:  r_long_polls <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Update clock state on each accepted request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sec_cnt    <= '0;
            r_blink_cnt  <= '0;
            r_blink      <= 1'b0;
            r_sec        <= '0;
            r_min        <= '0;
            r_hour       <= '0;
            r_mode       <= hhmmc_pkg::MODE_RUN;
            r_scan       <= '0;
            r_press      <= '{default: '0};
            r_long_fired <= 1'b0;
        end else if (req_fire) begin
            r_sec_cnt    <= n_sec_cnt;
            r_blink_cnt  <= n_blink_cnt;
            r_blink      <= n_blink;
            r_sec        <= n_sec;
            r_min        <= n_min;
            r_hour       <= n_hour;
            r_mode       <= n_mode;
            r_scan       <= n_scan;
            r_press      <= n_press;
            r_long_fired <= n_long_fired;
        end
    end

    // Hold the result until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (req_fire) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (req_fire) begin
            r_out <= n_out;
        end
    end

    // Every accepted request leaves a result pending
    a_result_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_fire |=> r_out_valid)
        else $error("accepted request left no result");

    // Buzzer only fires together with hour setting
    a_buzz_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.buzzer_pulse) |-> (r_out.set_mode == hhmmc_pkg::MODE_HOUR))
        else $error("buzzer pulse outside hour setting");

    // A driven digit has exactly one active strobe
    a_strobe_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.digit_enable != hhmmc_pkg::STROBE_BLANK)
        |-> $onehot(~r_out.digit_enable))
        else $error("digit strobe not one-hot");

    // Time stays in range
    a_time_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_hour <= hhmmc_pkg::HOUR_MAX) && (r_min <= hhmmc_pkg::MIN_MAX)
        && (r_sec <= hhmmc_pkg::SEC_MAX))
        else $error("time value out of range");

    // Poll results keep the display blank and the scan position
    a_poll_blank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (req_fire && i_req.payload.req_type == hhmmc_pkg::REQ_POLL)
        |=> (r_out.segments == hhmmc_pkg::SEG_BLANK) && $stable(r_scan))
        else $error("poll disturbed the display scan");

endmodule
